// File: rtl/q40dp_pkg.sv
// Shared widths, constants and types for the Q4_0 dot product requantizer.
package q40dp_pkg;

  // Field widths
  localparam int MaxLanes   = 8;
  localparam int CodeW      = 4;
  localparam int ActW       = 8;
  localparam int ProdW      = 12;  // (code - 8) * int8 fits in 12 signed bits
  localparam int PartW      = 18;  // block partial sum
  localparam int ScaleW     = 32;  // Q8.24 scales
  localparam int AccW       = 56;  // Q38.18 row accumulator
  localparam int BlkProdW   = PartW + ScaleW;
  localparam int TruncShift = 6;   // Q.24 * Q0 -> Q.18 drops six fraction bits
  localparam int HiW        = 64;  // upper magnitude half times output scale
  localparam int LoW        = 56;  // lower magnitude half times output scale
  localparam int Int8W      = 8;

  // Constants
  localparam logic [CodeW:0]     WeightBias     = 5'd8;
  localparam logic [ScaleW-1:0]  OutScaleReset  = 32'h0100_0000;  // 1.0 in Q8.24
  localparam logic [Int8W:0]     PosLimit       = 9'd127;
  localparam logic [Int8W:0]     NegLimit       = 9'd128;

  typedef logic signed [ProdW-1:0] lane_prod_t;

endpackage

// File: rtl/q40dp_lane.sv
// One lane: a 4-bit weight code minus the bias times one int8 activation.
module q40dp_lane
  import q40dp_pkg::*;
(
  input  logic [CodeW-1:0] code_i,
  input  logic [ActW-1:0]  act_i,
  output lane_prod_t       prod_o
);

  logic signed [CodeW:0]   weight;
  logic signed [ProdW-1:0] weight_ext;
  logic signed [ProdW-1:0] act_ext;

  // weight in -8..7
  assign weight     = $signed({1'b0, code_i}) - $signed(WeightBias);
  assign weight_ext = ProdW'(weight);
  assign act_ext    = ProdW'($signed(act_i));
  assign prod_o     = weight_ext * act_ext;

endmodule

// File: rtl/q40dp_merge.sv
// Merge stage: adds the lane products into the wrapping block partial sum.
module q40dp_merge
  import q40dp_pkg::*;
#(
  parameter int LANES = MaxLanes
) (
  input  lane_prod_t              prods_i [LANES],
  input  logic [PartW-1:0]        partial_i,
  output logic [PartW-1:0]        sum_o
);

  // narrow chain of at most eight adds, wraps in 18 bits
  always_comb begin
    logic [PartW-1:0] acc;
    acc = partial_i;
    for (int i = 0; i < LANES; i++) begin
      acc = acc + PartW'(prods_i[i]);
    end
    sum_o = acc;
  end

endmodule

// File: rtl/q4_0_dot_product_requantize.sv
// Top level: Q4_0 block dot product, block scaling, row accumulate, int8 requantize.
//
//   port group   dir  transfer payload
//   s_axis       in   tdata {block_scale, activation_bytes, weight_codes}, tuser block_end,
//                     tlast row_end
//   m_axis       out  tdata {row_int8, row_sum}, tuser clamped
//   cfg          in   cfg_wdata_i = output_scale, written when cfg_we_i is high
//
// An item that closes no block: the lanes and the merge adder update the partial sum in
// the cycle of the transfer. A block end then runs the 18x32 block-scale multiply and the
// 56-bit fold; a row end goes on with magnitude, 32x32 and 24x32 multiplies by the output
// scale, then rounding into the output register. Input is not ready until the sequencer is
// idle again. The result waits in the output register; a row end stalls in its last step
// only while a previous result is still untaken. Reset clears the sums and sets scale 1.0.
module q4_0_dot_product_requantize
  import q40dp_pkg::*;
#(
  parameter int LANES = MaxLanes
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [31:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [127:0] s_axis_tdata_i,   // weight_codes[31:0], activation_bytes[95:32],
                                         // block_scale[127:96]
  input  logic         s_axis_tuser_i,   // block_end
  input  logic         s_axis_tlast_i,   // row_end
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [63:0]  m_axis_tdata_o,   // row_sum[55:0], row_int8[63:56]
  output logic         m_axis_tuser_o    // clamped
);

  // Sequencer codes
  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StScale = 3'd1;
  localparam logic [2:0] StFold  = 3'd2;
  localparam logic [2:0] StMag   = 3'd3;
  localparam logic [2:0] StMulHi = 3'd4;
  localparam logic [2:0] StMulLo = 3'd5;
  localparam logic [2:0] StEmit  = 3'd6;

  logic [2:0]               state_q, state_d;
  logic [PartW-1:0]         partial_q, partial_d;
  logic [AccW-1:0]          acc_q, acc_d;
  logic [ScaleW-1:0]        out_scale_q;
  logic                     row_end_q, row_end_d;
  logic                     out_valid_q, out_valid_d;

  logic [PartW-1:0]         blk_part_q;
  logic [ScaleW-1:0]        blk_scale_q;
  logic signed [BlkProdW-1:0] blk_prod_q;
  logic                     neg_q;
  logic [AccW-1:0]          mag_q;
  logic [HiW-1:0]           hi_q;
  logic [LoW-1:0]           lo_q;
  logic [AccW-1:0]          out_sum_q;
  logic [Int8W-1:0]         out_int8_q;
  logic                     out_clamp_q;

  logic                     s_fire;
  logic                     closes;
  logic                     emit_ok;
  lane_prod_t               prods [LANES];
  logic [PartW-1:0]         merged;

  assign s_axis_tready_o = (state_q == StIdle);
  assign s_fire          = s_axis_tvalid_i & s_axis_tready_o;
  assign closes          = s_axis_tuser_i | s_axis_tlast_i;
  assign emit_ok         = (state_q == StEmit) & (~out_valid_q | m_axis_tready_i);

  // Lanes
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    q40dp_lane u_lane (
      .code_i (s_axis_tdata_i[CodeW*g +: CodeW]),
      .act_i  (s_axis_tdata_i[32 + ActW*g +: ActW]),
      .prod_o (prods[g])
    );
  end

  q40dp_merge #(.LANES(LANES)) u_merge (
    .prods_i   (prods),
    .partial_i (partial_q),
    .sum_o     (merged)
  );

  // Block fold: truncate Q.24 product toward minus infinity to Q.18
  logic [AccW-1:0] blk_q18;
  assign blk_q18 = AccW'(blk_prod_q >>> TruncShift);

  // Rounding: q2 = floor(mag * scale / 2^41), r = (q2 + 1) / 2
  logic [LoW:0]        low_sum;
  logic [HiW-18:0]     q2;
  logic [HiW-17:0]     q2_inc;
  logic [HiW-18:0]     r;
  logic [Int8W-1:0]    int8_val;
  logic                clamp_val;

  always_comb begin
    low_sum = (LoW+1)'({hi_q[16:0], 24'd0}) + (LoW+1)'(lo_q);
    q2      = hi_q[HiW-1:17] + (HiW-17)'(low_sum[LoW:41]);
    q2_inc  = (HiW-16)'(q2) + (HiW-16)'(1);
    r       = q2_inc[HiW-17:1];
    if (neg_q) begin
      clamp_val = (r > (HiW-17)'(NegLimit));
      int8_val  = clamp_val ? NegLimit[Int8W-1:0] : (~r[Int8W-1:0] + Int8W'(1));
    end else begin
      clamp_val = (r > (HiW-17)'(PosLimit));
      int8_val  = clamp_val ? PosLimit[Int8W-1:0] : r[Int8W-1:0];
    end
  end

  // Sequencer next state
  always_comb begin
    state_d     = state_q;
    partial_d   = partial_q;
    acc_d       = acc_q;
    row_end_d   = row_end_q;
    out_valid_d = out_valid_q & ~m_axis_tready_i;
    case (state_q)
      StIdle: begin
        if (s_fire) begin
          if (closes) begin
            partial_d = '0;
            row_end_d = s_axis_tlast_i;
            state_d   = StScale;
          end else begin
            partial_d = merged;
          end
        end
      end
      StScale: state_d = StFold;
      StFold: begin
        acc_d   = acc_q + blk_q18;
        state_d = row_end_q ? StMag : StIdle;
      end
      StMag:   state_d = StMulHi;
      StMulHi: state_d = StMulLo;
      StMulLo: state_d = StEmit;
      StEmit: begin
        if (emit_ok) begin
          out_valid_d = 1'b1;
          acc_d       = '0;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      partial_q   <= '0;
      acc_q       <= '0;
      out_scale_q <= OutScaleReset;
      row_end_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      partial_q   <= partial_d;
      acc_q       <= acc_d;
      row_end_q   <= row_end_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        out_scale_q <= cfg_wdata_i;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (s_fire && closes) begin
      blk_part_q  <= merged;
      blk_scale_q <= s_axis_tdata_i[127:96];
    end
    if (state_q == StScale) begin
      blk_prod_q <= BlkProdW'($signed(blk_part_q)) * BlkProdW'($signed(blk_scale_q));
    end
    if (state_q == StMag) begin
      neg_q <= acc_q[AccW-1];
      mag_q <= acc_q[AccW-1] ? (~acc_q + AccW'(1)) : acc_q;
    end
    if (state_q == StMulHi) begin
      hi_q <= HiW'(mag_q[AccW-1:24]) * HiW'(out_scale_q);
    end
    if (state_q == StMulLo) begin
      lo_q <= LoW'(mag_q[23:0]) * LoW'(out_scale_q);
    end
    if (emit_ok) begin
      out_sum_q   <= acc_q;
      out_int8_q  <= int8_val;
      out_clamp_q <= clamp_val;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_int8_q, out_sum_q};
  assign m_axis_tuser_o  = out_clamp_q;

  // Checks
  a_part_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && closes |=> partial_q == '0)
    else $error("partial sum not cleared after block close");

  a_emit_clears_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_ok |=> acc_q == '0 && state_q == StIdle && out_valid_q)
    else $error("row not cleared or result not posted after emit");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == StEmit)
    else $error("result posted outside emit step");

  a_clamp_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_clamp_q |-> (out_int8_q == PosLimit[Int8W-1:0] ||
                                     out_int8_q == NegLimit[Int8W-1:0]))
    else $error("clamp flag set without a saturated value");

endmodule

// File: tb/sv/row_result_checker.sv
// Checker for the Q4_0 requantizer: mirrors its sums, predicts each row result, compares.
`timescale 1ns / 100ps

module row_result_checker
  import q40dp_pkg::*;
#(
  parameter int LANES = MaxLanes
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [31:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid_i,
  input  logic         s_axis_tready_i,
  input  logic [127:0] s_axis_tdata_i,   // weight_codes[31:0], activation_bytes[95:32],
                                         // block_scale[127:96]
  input  logic         s_axis_tuser_i,   // block_end
  input  logic         s_axis_tlast_i,   // row_end
  input  logic         m_axis_tvalid_i,
  input  logic         m_axis_tready_i,
  input  logic [63:0]  m_axis_tdata_i,   // row_sum[55:0], row_int8[63:56]
  input  logic         m_axis_tuser_i,   // clamped
  output int           fail_count_o,
  output int           pending_o
);

  typedef struct packed {
    logic [AccW-1:0]  sum;
    logic [Int8W-1:0] val;
    logic             clamp;
  } row_result_t;

  row_result_t             rows_due[$];
  logic [ScaleW-1:0]       out_scale;
  logic signed [PartW-1:0] blk_sum;
  logic [AccW-1:0]         row_acc;
  int                      errors = 0;

  assign fail_count_o = errors;

  // Sum of (code - 8) * activation over the active lanes, wrapped to the partial width
  function automatic logic signed [PartW-1:0] lane_dot(logic [31:0] codes,
                                                       logic [63:0] acts);
    int total;
    total = 0;
    for (int i = 0; i < LANES; i++) begin
      total += (int'(codes[CodeW*i +: CodeW]) - 8) * int'($signed(acts[ActW*i +: ActW]));
    end
    return total[PartW-1:0];
  endfunction

  // Row sum times output scale, rounded half away from zero, clamped to int8
  function automatic row_result_t requantize(logic [AccW-1:0] acc, logic [ScaleW-1:0] scale);
    row_result_t res;
    logic        neg;
    logic [AccW-1:0] mag;
    logic [87:0] full;
    logic [87:0] mag_int;
    neg = acc[AccW-1];
    mag = neg ? (~acc + 56'd1) : acc;
    full = 88'(mag) * 88'(scale);
    // full / 2^41 is twice the quotient; add one and halve to round
    mag_int = ((full >> 41) + 88'd1) >> 1;
    res.sum = acc;
    res.clamp = 1'b0;
    if (neg) begin
      if (mag_int > 88'd128) begin
        mag_int = 88'd128;
        res.clamp = 1'b1;
      end
      res.val = -mag_int[Int8W-1:0];
    end else begin
      if (mag_int > 88'd127) begin
        mag_int = 88'd127;
        res.clamp = 1'b1;
      end
      res.val = mag_int[Int8W-1:0];
    end
    return res;
  endfunction

  // Compare one output transfer with the oldest prediction
  task automatic check_row(input logic [63:0] data, input logic clamp);
    row_result_t want;
    if (rows_due.size() == 0) begin
      errors++;
      $display("%0t: unexpected result: expected none, got sum %0d int8 %0d", $time,
               $signed(data[AccW-1:0]), $signed(data[63:56]));
    end else begin
      want = rows_due.pop_front();
      if (data[AccW-1:0] !== want.sum) begin
        errors++;
        $display("%0t: row_sum mismatch: expected %0d, got %0d", $time,
                 $signed(want.sum), $signed(data[AccW-1:0]));
      end
      if (data[63:56] !== want.val) begin
        errors++;
        $display("%0t: row_int8 mismatch: expected %0d, got %0d", $time,
                 $signed(want.val), $signed(data[63:56]));
      end
      if (clamp !== want.clamp) begin
        errors++;
        $display("%0t: clamped mismatch: expected %0b, got %0b", $time, want.clamp, clamp);
      end
    end
  endtask

  // Advance the mirrored state by one input transfer
  task automatic take_item(input logic [127:0] data, input logic bend, input logic rend);
    longint prod;
    blk_sum = blk_sum + lane_dot(data[31:0], data[95:32]);
    if (bend || rend) begin
      // block scale product, floor to Q.18, wrapping fold into the row
      prod = longint'(blk_sum) * longint'($signed(data[127:96]));
      row_acc = row_acc + 56'(prod >>> TruncShift);
      blk_sum = '0;
    end
    if (rend) begin
      rows_due.push_back(requantize(row_acc, out_scale));
      row_acc = '0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_scale = OutScaleReset;
      blk_sum = '0;
      row_acc = '0;
      rows_due.delete();
      pending_o <= 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) check_row(m_axis_tdata_i, m_axis_tuser_i);
      if (cfg_we_i) out_scale = cfg_wdata_i;
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        take_item(s_axis_tdata_i, s_axis_tuser_i, s_axis_tlast_i);
      end
      pending_o <= rows_due.size();
    end
  end

endmodule

// File: tb/sv/q4_0_dot_product_requantize_tb.sv
// Testbench top for the Q4_0 requantizer: clock, reset, stimulus, sink and verdict.
`timescale 1ns / 100ps

module q4_0_dot_product_requantize_tb;
  import q40dp_pkg::*;

  localparam int IdlePct      = 13;
  localparam int DrainCycles  = 12;
  localparam int StallLimit   = 1000;
  localparam int Phases       = 12;
  localparam int PhaseItems   = 125;
  localparam int LongRowItems = 40;  // maximal blocks in one row, drives the row sum far out

  logic         clk_i     = 1'b0;
  logic         rst_ni    = 1'b0;
  logic         cfg_we    = 1'b0;
  logic [31:0]  cfg_wdata = '0;
  logic         s_valid   = 1'b0;
  logic [127:0] s_data    = '0;
  logic         s_user    = 1'b0;
  logic         s_last    = 1'b0;
  logic         m_ready   = 1'b0;
  logic         s_ready;
  logic         m_valid;
  logic [63:0]  m_data;
  logic         m_user;
  int           fails;
  int           pending;
  int           quiet_cycles = 0;
  int           sent = 0;
  bit           calm = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  q4_0_dot_product_requantize dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_user),
    .s_axis_tlast_i (s_last),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tuser_o (m_user)
  );

  row_result_checker #(.LANES(MaxLanes)) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_i(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_user),
    .s_axis_tlast_i (s_last),
    .m_axis_tvalid_i(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_i (m_data),
    .m_axis_tuser_i (m_user),
    .fail_count_o   (fails),
    .pending_o      (pending)
  );

  function automatic bit take_break();
    return !calm && ($urandom_range(0, 99) < IdlePct);
  endfunction

  // Magnitudes spread over all octaves
  function automatic logic [31:0] shaped_word();
    return $urandom >> $urandom_range(0, 31);
  endfunction

  function automatic logic [31:0] rand_block_scale();
    logic [31:0] v;
    v = shaped_word();
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  // Result sink with random stalls
  always @(posedge clk_i) begin
    m_ready <= !take_break();
  end

  // Watchdog: cycles without any transfer or register write
  always @(posedge clk_i) begin
    if (!rst_ni || (s_valid && s_ready) || (m_valid && m_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One input transfer, with random idle cycles ahead of it
  task automatic push_item(input logic [31:0] codes, input logic [63:0] acts,
                           input logic [31:0] bscale, input logic bend, input logic rend);
    while (take_break()) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data <= {bscale, acts, codes};
    s_user <= bend;
    s_last <= rend;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
  endtask

  task automatic push_random_item(input logic bend, input logic rend);
    logic [31:0] codes;
    logic [63:0] acts;
    codes = $urandom;
    acts = {$urandom, $urandom};
    // occasional extreme lanes
    case ($urandom_range(0, 15))
      0: begin
        codes = '0;
        acts = {8{8'h80}};
      end
      1: begin
        codes = '1;
        acts = {8{8'h7F}};
      end
      2: acts = {8{8'h80}};
      3: codes = {8{4'h8}};
      default: ;
    endcase
    push_item(codes, acts, rand_block_scale(), bend, rend);
    sent++;
  endtask

  // Mostly well-formed rows of blocks, with some stray flags
  task automatic send_row();
    int   nblk;
    int   nitems;
    logic bend;
    logic rend;
    nblk = $urandom_range(1, 4);
    for (int b = 0; b < nblk; b++) begin
      nitems = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 4;
      for (int k = 0; k < nitems; k++) begin
        bend = (k == nitems - 1);
        rend = bend && (b == nblk - 1);
        if (rend && $urandom_range(0, 5) == 0) bend = 1'b0;
        if ($urandom_range(0, 9) == 0) {bend, rend} = 2'($urandom);
        push_random_item(bend, rend);
      end
    end
  endtask

  // Let every expected row arrive, then give the pipeline time to settle
  task automatic wait_idle();
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_out_scale(input logic [31:0] value);
    cfg_wdata <= value;
    cfg_we <= 1'b1;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [31:0] scale;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, output scale at its reset value of 1.0
    push_item('0, {8{8'h80}}, 32'h7FFF_FFFF, 1'b1, 1'b0);               // largest lane sum
    push_item('1, {8{8'h7F}}, 32'h8000_0000, 1'b1, 1'b1);               // clamps high
    push_item(32'h8888_8889, 64'h01, 32'h0080_0000, 1'b1, 1'b1);        // +0.5 rounds up
    push_item(32'h8888_8889, 64'hFF, 32'h0080_0000, 1'b1, 1'b1);        // -0.5 rounds down
    push_item(32'h8888_8889, 64'h03, 32'h0080_0000, 1'b1, 1'b1);        // 1.5 rounds to 2
    push_item($urandom, {$urandom, $urandom}, 32'h0000_1000, 1'b0, 1'b1); // row end only
    // partial sum overflow: 17 maximal items in one block
    for (int i = 0; i < 16; i++) push_item('0, {8{8'h80}}, $urandom, 1'b0, 1'b0);
    push_item('0, {8{8'h80}}, 32'h0000_0040, 1'b1, 1'b1);
    wait_idle();

    // Random phases, each under its own output scale
    for (int p = 0; p < Phases; p++) begin
      case (p)
        0: scale = 32'h0000_0000;
        1: scale = 32'hFFFF_FFFF;
        2: scale = 32'h0000_0001;
        3: scale = 32'h0100_0000;
        4: scale = 32'h0080_0000;
        default: scale = shaped_word();
      endcase
      write_out_scale(scale);
      calm = (p == 3);
      sent = 0;
      while (sent < PhaseItems) send_row();
      push_random_item(1'b1, 1'b1);
      wait_idle();
    end
    calm = 1'b0;

    // One long row of maximal blocks pushes the row sum far from zero
    write_out_scale(32'h0000_0100);
    for (int i = 0; i < LongRowItems; i++) begin
      push_item('0, {8{8'h80}}, 32'h8000_0000, 1'b1, 1'b0);
    end
    push_item('0, {8{8'h80}}, 32'h8000_0000, 1'b1, 1'b1);
    wait_idle();

    if (fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
